/* rtl/core/tis_pkg.sv */
package tis_pkg;

  // Width of the tolerance register, which holds an unsigned Q17.0 magnitude.
  localparam int TOL_W = 17;

  typedef enum logic [0:0] {
    CFG_ISO_LEVEL = 1'b0,
    CFG_EQ_TOL    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

/* rtl/core/tis_front.sv */
module tis_front import tis_pkg::*; #(
  parameter int DW = 32,
  parameter int CW = 32,
  parameter int IW = 384,
  parameter int FW = 793
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wen,
  input  logic [0:0]    cfg_index,
  input  logic [CW-1:0] cfg_wdata,
  input  logic [IW-1:0] in_data,
  output logic [FW-1:0] rec
);

  localparam int NB = DW + 1;
  localparam int LW = DW + 3 * NB + 1;
  localparam int EW = (NB > TOL_W) ? NB : TOL_W;

  logic [DW-1:0]    iso_r;
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= '0;
      tol_r <= TOL_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ISO_LEVEL: iso_r <= cfg_wdata[DW-1:0];
        CFG_EQ_TOL:    tol_r <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [NB-1:0] mag(input logic [NB-1:0] x);
    return x[NB-1] ? (~x + 1'b1) : x;
  endfunction

  // Lane record, low bits first: f0, |num|, |f1-f0|, |den|, negate.
  function automatic logic [LW-1:0] lane_pt(input logic [DW-1:0] f0, input logic [DW-1:0] f1,
                                            input logic [DW-1:0] c0, input logic [DW-1:0] c1,
                                            input logic [DW-1:0] iso);
    logic [NB-1:0] num;
    logic [NB-1:0] den;
    logic [NB-1:0] dc;
    logic          neg;
    num = {iso[DW-1], iso} - {c0[DW-1], c0};
    den = {c1[DW-1], c1} - {c0[DW-1], c0};
    dc  = {f1[DW-1], f1} - {f0[DW-1], f0};
    neg = num[NB-1] ^ den[NB-1] ^ dc[NB-1];
    return {neg, mag(den), mag(dc), mag(num), f0};
  endfunction

  // A fixed point passes f0 through: zero product over a unit divisor.
  function automatic logic [LW-1:0] lane_fix(input logic [DW-1:0] v);
    return {1'b0, NB'(1), {NB{1'b0}}, {NB{1'b0}}, v};
  endfunction

  logic [DW-1:0] cv [3];
  logic [DW-1:0] fv [3][3];
  logic [LW-1:0] pt_l [3][3];
  logic [2:0]    eq;
  logic [2:0]    hi;
  logic [2:0]    xs;
  logic [LW-1:0] lane [6];
  logic          seg_valid;

  always_comb begin
    logic [NB-1:0] dd;
    logic [NB-1:0] dl;
    int k;
    for (int j = 0; j < 3; j++) begin
      cv[j] = in_data[j*DW +: DW];
      for (int m = 0; m < 3; m++) begin
        fv[j][m] = in_data[(3 + 3*j + m)*DW +: DW];
      end
    end
    for (int j = 0; j < 3; j++) begin
      k = (j == 2) ? 0 : j + 1;
      dd = {cv[j][DW-1], cv[j]} - {cv[k][DW-1], cv[k]};
      dl = {cv[j][DW-1], cv[j]} - {iso_r[DW-1], iso_r};
      eq[j] = (EW'(mag(dd)) < EW'(tol_r)) && (EW'(mag(dl)) < EW'(tol_r));
      hi[j] = $signed(cv[j]) >= $signed(iso_r);
      for (int m = 0; m < 3; m++) begin
        pt_l[j][m] = lane_pt(fv[j][m], fv[k][m], cv[j], cv[k], iso_r);
      end
    end
    for (int j = 0; j < 3; j++) begin
      xs[j] = hi[j] ^ hi[(j == 2) ? 0 : j + 1];
    end
  end

  // The first edge lying on the level wins over any crossing.
  always_comb begin
    seg_valid = 1'b1;
    for (int m = 0; m < 3; m++) begin
      lane[m]     = lane_fix('0);
      lane[3 + m] = lane_fix('0);
    end
    if (eq[0]) begin
      for (int m = 0; m < 3; m++) begin
        lane[m] = lane_fix(fv[0][m]); lane[3 + m] = lane_fix(fv[1][m]);
      end
    end else if (eq[1]) begin
      for (int m = 0; m < 3; m++) begin
        lane[m] = lane_fix(fv[1][m]); lane[3 + m] = lane_fix(fv[2][m]);
      end
    end else if (eq[2]) begin
      for (int m = 0; m < 3; m++) begin
        lane[m] = lane_fix(fv[2][m]); lane[3 + m] = lane_fix(fv[0][m]);
      end
    end else if (xs[0] && xs[1]) begin
      for (int m = 0; m < 3; m++) begin
        lane[m] = pt_l[0][m]; lane[3 + m] = pt_l[1][m];
      end
    end else if (xs[0] && xs[2]) begin
      for (int m = 0; m < 3; m++) begin
        lane[m] = pt_l[0][m]; lane[3 + m] = pt_l[2][m];
      end
    end else if (xs[1] && xs[2]) begin
      for (int m = 0; m < 3; m++) begin
        lane[m] = pt_l[1][m]; lane[3 + m] = pt_l[2][m];
      end
    end else begin
      seg_valid = 1'b0;
    end
  end

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      rec[l*LW +: LW] = lane[l];
    end
    rec[FW-1] = seg_valid;
  end

endmodule

/* rtl/core/tis_fifo.sv */
module tis_fifo import tis_pkg::*; #(
  parameter int W = 793
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output q_status_t    status
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] count_r, count_nxt;

  always_comb begin
    wr_nxt    = push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
    count_nxt = count_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  assign pop_data         = mem_r[rd_r];
  assign status.full      = (count_r == NW'(DEPTH));
  assign status.not_empty = (count_r != '0);

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0) else $error("pop from empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full) else $error("push into full queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1) else $error("count lost a push");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH)) else $error("queue count overflow");

endmodule

/* rtl/core/tis_lerp.sv */
module tis_lerp #(
  parameter int DW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DW+3*(DW+1):0]     lane,
  output logic [DW-1:0]            result
);

  localparam int NB = DW + 1;
  localparam int PW = 2 * DW + 1;

  logic [DW-1:0]   f0_in;
  logic [NB-1:0]   a_in;
  logic [NB-1:0]   b_in;
  logic [NB-1:0]   d_in;
  logic            neg_in;
  logic [2*NB-1:0] prod;

  assign f0_in  = lane[DW-1:0];
  assign a_in   = lane[DW +: NB];
  assign b_in   = lane[DW+NB +: NB];
  assign d_in   = lane[DW+2*NB +: NB];
  assign neg_in = lane[DW+3*NB];
  assign prod   = a_in * b_in;

  logic [PW-1:0] rem_r [NB];
  logic [NB-1:0] q_r   [NB+1];
  logic [NB-1:0] d_r   [NB];
  logic [DW-1:0] f0_r  [NB+1];
  logic          neg_r [NB+1];
  logic [DW-1:0] result_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= prod[PW-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= d_in;
      f0_r[0]  <= f0_in;
      neg_r[0] <= neg_in;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NB; k++) begin : g_div
    localparam int SH = NB - 1 - k;
    logic [PW-1:0] dsh;
    logic          ge;
    assign dsh = {{(PW-NB){1'b0}}, d_r[k]} << SH;
    assign ge  = rem_r[k] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]   <= {q_r[k][NB-2:0], ge};
        f0_r[k+1]  <= f0_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
    if (k < NB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
          d_r[k+1]   <= d_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= neg_r[NB] ? f0_r[NB] - q_r[NB][DW-1:0] : f0_r[NB] + q_r[NB][DW-1:0];
    end
  end

  assign result = result_r;

endmodule

/* rtl/core/tis_back.sv */
module tis_back import tis_pkg::*; #(
  parameter int DW = 32,
  parameter int FW = 793,
  parameter int OW = 192
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [FW-1:0] q_rec,
  input  q_status_t     q_status,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic          out_tuser,
  output logic [OW-1:0] out_tdata
);

  localparam int NB = DW + 1;
  localparam int LW = DW + 3 * NB + 1;
  localparam int NS = DW + 3;

  logic          en;
  logic [NS-1:0] v_r;
  logic [NS-1:0] sv_r;
  logic [DW-1:0] res [6];

  // The whole pipeline advances together; it freezes only while the
  // finished result is held.
  assign en  = !v_r[NS-1] || out_tready;
  assign pop = en && q_status.not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], q_status.not_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r <= {sv_r[NS-2:0], q_rec[FW-1]};
    end
  end

  for (genvar l = 0; l < 6; l++) begin : g_lane
    tis_lerp #(.DW(DW)) u_lerp (
      .clk   (clk),
      .en    (en),
      .lane  (q_rec[l*LW +: LW]),
      .result(res[l])
    );
  end

  always_comb begin
    out_tdata = '0;
    for (int l = 0; l < 6; l++) begin
      out_tdata[l*DW +: DW] = res[l];
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tuser  = sv_r[NS-1];

endmodule

/* rtl/core/triangle_isoline_segment_unit.sv */
// Channel  Direction  Transaction contents
// in_      slave      one triangle: three vertex values, three vertex positions
// out_     master     one segment: valid flag in tuser, two endpoints in tdata
// cfg_     write      iso_level (index 0), equal_tolerance (index 1)
//
// One triangle is accepted per cycle while the four-entry queue is not full; after it
// leaves the queue, its result is formed by the bit-per-stage pipelined dividers,
// one per output coordinate.
// Synchronous reset clears the queue, pipeline valids and iso_level; equal_tolerance resets to 1.
// A stalled output freezes the back pipeline; the queue keeps taking input until full.
module triangle_isoline_segment_unit import tis_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              cfg_wen,
  input  logic [0:0]                                        cfg_index,
  input  logic [((DATA_WIDTH > TOL_W) ? DATA_WIDTH : TOL_W)-1:0] cfg_wdata,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // value_a, value_b, value_c, ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]                in_tdata,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // segment_valid
  output logic                                              out_tuser,
  // start_x, start_y, start_z, end_x, end_y, end_z
  output logic [((6*DATA_WIDTH+7)/8)*8-1:0]                 out_tdata
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = (DW > TOL_W) ? DW : TOL_W;
  localparam int IW = ((12*DW+7)/8)*8;
  localparam int OW = ((6*DW+7)/8)*8;
  localparam int LW = DW + 3 * (DW + 1) + 1;
  localparam int FW = 6 * LW + 1;

  logic [FW-1:0] front_rec;
  logic [FW-1:0] q_rec;
  q_status_t     q_status;
  logic          push;
  logic          pop;

  assign in_tready = rst_n && !q_status.full;
  assign push      = in_tvalid && in_tready;

  tis_front #(.DW(DW), .CW(CW), .IW(IW), .FW(FW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_tdata),
    .rec      (front_rec)
  );

  tis_fifo #(.W(FW)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(front_rec),
    .pop      (pop),
    .pop_data (q_rec),
    .status   (q_status)
  );

  tis_back #(.DW(DW), .FW(FW), .OW(OW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rec     (q_rec),
    .q_status  (q_status),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule
